[hdl/tspat_pkg.sv]
`timescale 1ns / 1ps
// shared constants and types for the pat section parser
// no dependencies
package tspat_pkg;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_BODY   = 2'd2;
  localparam logic [1:0] PH_SKIP   = 2'd3;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_REG = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  localparam logic       KIND_BYTE   = 1'b0;
  localparam logic       KIND_FORGET = 1'b1;
  localparam logic [5:0] NO_VERSION  = 6'h3f;
  localparam logic [7:0] PAT_TABLE_ID = 8'h00;
  localparam logic [11:0] LEN_MIN    = 12'd5;
  localparam logic [11:0] LEN_MAX    = 12'd1021;

  typedef struct packed {
    logic       kind;
    logic       section_start;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] program_number;
    logic [12:0] pmt_pid;
    logic [4:0]  table_version;
  } res_t;

endpackage

[hdl/tspat_core.sv]
`timescale 1ns / 1ps
// parse state and per-byte update logic for one section byte or forget request
// depends on tspat_pkg
module tspat_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  tspat_pkg::item_t item,
  output logic            res_valid,
  output tspat_pkg::res_t res
);

  logic [5:0]  stored_ver_r, stored_ver_nxt;
  logic [9:0]  pos_r, pos_nxt;
  logic [9:0]  body_len_r, body_len_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [23:0] hdr_r, hdr_nxt;
  logic [7:0]  entry_cnt_r, entry_cnt_nxt;
  logic [15:0] first_prog_r, first_prog_nxt;
  logic [12:0] first_pid_r, first_pid_nxt;

  logic [11:0] sec_len;
  logic [4:0]  cur_ver;
  logic        hdr_ok;
  logic [7:0]  b;

  assign b       = item.data_byte;
  assign sec_len = {hdr_r[11:8], b};
  assign cur_ver = hdr_r[5:1];
  assign hdr_ok  = (hdr_r[23:16] == tspat_pkg::PAT_TABLE_ID) && hdr_r[15] && !hdr_r[14]
                   && (body_len_r[1:0] == 2'd0) && (body_len_r[9:2] != 8'd0);

  always_comb begin
    stored_ver_nxt = stored_ver_r;
    pos_nxt        = pos_r;
    body_len_nxt   = body_len_r;
    phase_nxt      = phase_r;
    hdr_nxt        = hdr_r;
    entry_cnt_nxt  = entry_cnt_r;
    first_prog_nxt = first_prog_r;
    first_pid_nxt  = first_pid_r;
    res_valid      = 1'b0;
    res            = '0;

    if (item.kind != tspat_pkg::KIND_BYTE) begin
      stored_ver_nxt = tspat_pkg::NO_VERSION;
    end else if (item.section_start) begin
      if ((phase_r == tspat_pkg::PH_HEADER) || (phase_r == tspat_pkg::PH_BODY)) begin
        res_valid = 1'b1;
        res.status = tspat_pkg::ST_BAD;
        if ((phase_r == tspat_pkg::PH_BODY) || (pos_r > 10'd5)) begin
          res.table_version = cur_ver;
        end
      end
      phase_nxt      = tspat_pkg::PH_HEADER;
      hdr_nxt        = {b, 16'd0};
      pos_nxt        = 10'd1;
      body_len_nxt   = '0;
      entry_cnt_nxt  = '0;
      first_prog_nxt = '0;
      first_pid_nxt  = '0;
    end else if (phase_r == tspat_pkg::PH_HEADER) begin
      pos_nxt = 10'(pos_r + 10'd1);
      priority if (pos_r == 10'd1) begin
        hdr_nxt[15:8] = b;
      end else if (pos_r == 10'd2) begin
        hdr_nxt[7:0] = b;
        if ((sec_len < tspat_pkg::LEN_MIN) || (sec_len > tspat_pkg::LEN_MAX)) begin
          res_valid  = 1'b1;
          res.status = tspat_pkg::ST_BAD;
          phase_nxt  = tspat_pkg::PH_SKIP;
          pos_nxt    = pos_r;
        end else begin
          body_len_nxt = 10'(sec_len - tspat_pkg::LEN_MIN);
        end
      end else if (pos_r == 10'd5) begin
        hdr_nxt[7:0] = b;
      end else if (pos_r == 10'd7) begin
        if (!hdr_ok) begin
          res_valid         = 1'b1;
          res.status        = tspat_pkg::ST_BAD;
          res.table_version = cur_ver;
          phase_nxt         = tspat_pkg::PH_SKIP;
          pos_nxt           = pos_r;
        end else begin
          entry_cnt_nxt = 8'((body_len_r - 10'd4) >> 2);
          phase_nxt     = tspat_pkg::PH_BODY;
        end
      end else begin
      end
    end else if (phase_r == tspat_pkg::PH_BODY) begin
      // first program entry occupies bytes 8..11 when the body holds one
      if ((pos_r[9:2] == 8'd2) && (body_len_r[9:3] != 7'd0)) begin
        unique case (pos_r[1:0])
          2'd0: first_prog_nxt[15:8] = b;
          2'd1: first_prog_nxt[7:0]  = b;
          2'd2: first_pid_nxt        = {b[4:0], 8'd0};
          default: first_pid_nxt[7:0] = b;
        endcase
      end
      if (pos_r == 10'(body_len_r + 10'd7)) begin
        phase_nxt         = tspat_pkg::PH_IDLE;
        pos_nxt           = '0;
        res_valid         = 1'b1;
        res.table_version = cur_ver;
        if (!hdr_r[0] || ({1'b0, cur_ver} == stored_ver_r)) begin
          res.status = tspat_pkg::ST_OK;
        end else if (entry_cnt_r > 8'd1) begin
          res.status = tspat_pkg::ST_BAD;
        end else begin
          stored_ver_nxt = {1'b0, cur_ver};
          if ((entry_cnt_r == 8'd1) && (first_prog_r != 16'd0)) begin
            res.status         = tspat_pkg::ST_REG;
            res.program_number = first_prog_r;
            res.pmt_pid        = first_pid_r;
          end else begin
            res.status = tspat_pkg::ST_OK;
          end
        end
      end else begin
        pos_nxt = 10'(pos_r + 10'd1);
      end
    end else begin
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_ver_r <= tspat_pkg::NO_VERSION;
      pos_r        <= '0;
      body_len_r   <= '0;
      phase_r      <= tspat_pkg::PH_IDLE;
      hdr_r        <= '0;
      entry_cnt_r  <= '0;
      first_prog_r <= '0;
      first_pid_r  <= '0;
    end else if (fire) begin
      stored_ver_r <= stored_ver_nxt;
      pos_r        <= pos_nxt;
      body_len_r   <= body_len_nxt;
      phase_r      <= phase_nxt;
      hdr_r        <= hdr_nxt;
      entry_cnt_r  <= entry_cnt_nxt;
      first_prog_r <= first_prog_nxt;
      first_pid_r  <= first_pid_nxt;
    end
  end

endmodule

[hdl/ts_pat_section_parser.sv]
`timescale 1ns / 1ps
// throughput: one request per cycle while the output register is empty or out_stall is
// low; else in_stall rises and the input register and the parse state hold
// reset: synchronous active-low rst_n clears valids, parse state and stored version
// top level: input register, tspat_core, output register; depends on tspat_pkg
module ts_pat_section_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic        in_section_start,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [15:0] out_program_number,
  output logic [12:0] out_pmt_pid,
  output logic [4:0]  out_table_version
);

  logic             s1_valid_r;
  tspat_pkg::item_t s1_item_r;
  logic             out_valid_r;
  tspat_pkg::res_t  out_res_r;

  logic             adv;
  logic             fire;
  logic             res_valid;
  tspat_pkg::res_t  res;

  assign adv      = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && adv;
  assign in_stall = s1_valid_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_item_r <= '{kind: in_kind, section_start: in_section_start,
                     data_byte: in_data_byte};
    end
  end

  tspat_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (s1_item_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_res_r.status;
  assign out_program_number = out_res_r.program_number;
  assign out_pmt_pid        = out_res_r.pmt_pid;
  assign out_table_version  = out_res_r.table_version;

endmodule
